[hw/rtl/assert_macros.svh]
// assertion helpers used by the matcher rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clk edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// plain condition that must hold on every rising clk edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

[hw/rtl/wcsm_pkg.sv]
`default_nettype none
package wcsm_pkg;

    localparam int PATTERN_MAX = 64;
    localparam int CHAR_BITS   = 21;
    localparam int POS_BITS    = 32;

    // fixed by the item and register formats
    localparam int ACT_BITS = 2;
    localparam int IDX_BITS = 6;
    localparam int LEN_BITS = 7;

    localparam int SEL_BITS  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int FILL_BITS = $clog2(PATTERN_MAX + 1);

    localparam int IN_DATA_BITS  = ((IDX_BITS + CHAR_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((POS_BITS + 7) / 8) * 8;

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    // register index of pattern_length
    localparam logic [APB_ADDR_BITS-3:0] REG_PATTERN_LENGTH = '0;

    typedef enum logic [ACT_BITS-1:0] {
        ACT_LOAD = 2'd0,
        ACT_TEXT = 2'd1,
        ACT_NEW  = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    // broadcast control for the cell row
    typedef struct packed {
        logic                 step;
        logic                 valid;
        logic                 clear;
        logic                 load;
        logic [IDX_BITS-1:0]  load_idx;
        logic [CHAR_BITS-1:0] chr;
    } cell_ctrl_t;

endpackage
`default_nettype wire

[hw/rtl/wide_char_substring_matcher.sv]
// wide character substring matcher
// s_axis carries one word per action: load a pattern character, a text
// character, or start a new text (tuser selects which). only text words
// produce a result on m_axis; tuser flags a match ending at that character
// and tdata gives the start position of the match (zero when no match).
// pattern_length is written over apb at address 0; the user must write it
// only while the block is idle, which the block does not enforce. matching
// is done by a row of cells, one per pattern position. each cell holds a
// pattern character, a window character and a prefix-match bit that moves
// to its neighbor as each text character is broadcast. a text word's result
// sits in the output register the cycle after acceptance and holds there
// until m_axis_tready. a pattern load is followed by a replay of the stored
// window through the row (skipped when the window is empty) to rebuild the
// prefix bits; s_axis_tready is low during the replay.
// while a result is stalled, s_axis_tready stays low unless the result is
// taken in the same cycle.
// reset clears the window fill, the position counter, the prefix bits,
// pattern_length and the output register; pattern characters are undefined
// until written.
`default_nettype none
`include "assert_macros.svh"
module wide_char_substring_matcher
    import wcsm_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    // input words
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic [IN_DATA_BITS-1:0]  s_axis_tdata,  // pattern_index, char_value, zero pad
    input  wire logic [ACT_BITS-1:0]      s_axis_tuser,  // action

    // result words
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    output logic [OUT_DATA_BITS-1:0]      m_axis_tdata,  // match_start
    output logic                          m_axis_tuser,  // match_found

    // register port
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output logic                          pready
);

    typedef enum logic {
        S_RUN,
        S_REPLAY
    } state_t;

    state_t                state_reg, state_next;
    logic [SEL_BITS-1:0]   cnt_reg, cnt_next;
    logic [FILL_BITS-1:0]  fill_reg, fill_next;
    logic [POS_BITS-1:0]   pos_reg, pos_next;
    logic [LEN_BITS-1:0]   len_reg, len_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_found_reg, out_found_next;
    logic [POS_BITS-1:0]   out_start_reg, out_start_next;

    logic                  in_acc;
    action_t               action;
    logic [IDX_BITS-1:0]   in_idx;
    logic [CHAR_BITS-1:0]  in_char;
    logic                  cfg_wr;
    logic                  text_acc;

    cell_ctrl_t            ctrl;
    logic [PATTERN_MAX-1:0] match_next;
    logic [CHAR_BITS-1:0]  win_last;

    logic                  len_ok;
    logic [SEL_BITS-1:0]   len_sel;
    logic                  hit;
    logic                  replay_valid;
    logic [FILL_BITS:0]    replay_sum;

    // field unpacking
    assign action  = action_t'(s_axis_tuser);
    assign in_idx  = s_axis_tdata[IDX_BITS-1:0];
    assign in_char = s_axis_tdata[IDX_BITS +: CHAR_BITS];

    // accept only when running and the output register can take a result
    assign s_axis_tready = (state_reg == S_RUN) && (!out_valid_reg || m_axis_tready);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign text_acc      = in_acc && (action == ACT_TEXT);

    // apb register port, single register at address 0
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[APB_ADDR_BITS-1:2] == REG_PATTERN_LENGTH);
    assign prdata = (paddr[APB_ADDR_BITS-1:2] == REG_PATTERN_LENGTH)
                    ? APB_DATA_BITS'(len_reg) : '0;

    // replay feeds the window oldest first; entries older than the text are masked
    assign replay_sum   = (FILL_BITS+1)'(cnt_reg) + (FILL_BITS+1)'(fill_reg);
    assign replay_valid = (replay_sum >= (FILL_BITS+1)'(PATTERN_MAX));

    // match select on the prefix bit of length pattern_length
    assign len_ok  = (len_reg != '0) && (len_reg <= LEN_BITS'(PATTERN_MAX));
    assign len_sel = SEL_BITS'(len_reg - LEN_BITS'(1));
    assign hit     = len_ok && match_next[len_sel];

    always_comb
    begin
        ctrl          = '0;
        ctrl.load_idx = in_idx;
        ctrl.chr      = in_char;
        if (state_reg == S_REPLAY)
        begin
            // rotate the window through the row, rebuilding prefix bits
            ctrl.step  = 1'b1;
            ctrl.valid = replay_valid;
            ctrl.chr   = win_last;
        end
        else if (in_acc)
        begin
            case (action)
                ACT_LOAD:
                begin
                    ctrl.load  = 1'b1;
                    ctrl.clear = 1'b1;
                end
                ACT_TEXT:
                begin
                    ctrl.step  = 1'b1;
                    ctrl.valid = 1'b1;
                end
                ACT_NEW:
                begin
                    ctrl.clear = 1'b1;
                end
                default:
                begin
                    ctrl.step = 1'b0;
                end
            endcase
        end
    end

    wcsm_chain u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .match_next (match_next),
        .win_last   (win_last)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        fill_next      = fill_reg;
        pos_next       = pos_reg;
        len_next       = len_reg;
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_start_next = out_start_reg;

        if (cfg_wr)
        begin
            len_next = pwdata[LEN_BITS-1:0];
        end

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_REPLAY:
            begin
                cnt_next = cnt_reg + SEL_BITS'(1);
                if (cnt_reg == SEL_BITS'(PATTERN_MAX - 1))
                begin
                    state_next = S_RUN;
                    cnt_next   = '0;
                end
            end
            S_RUN:
            begin
                if (in_acc)
                begin
                    case (action)
                        ACT_LOAD:
                        begin
                            // nothing to rebuild when the window is empty
                            if (fill_reg != '0)
                            begin
                                state_next = S_REPLAY;
                                cnt_next   = '0;
                            end
                        end
                        ACT_TEXT:
                        begin
                            if (fill_reg < FILL_BITS'(PATTERN_MAX))
                            begin
                                fill_next = fill_reg + FILL_BITS'(1);
                            end
                            pos_next       = pos_reg + POS_BITS'(1);
                            out_valid_next = 1'b1;
                            out_found_next = hit;
                            out_start_next = hit
                                ? (pos_reg - POS_BITS'(len_reg) + POS_BITS'(1))
                                : '0;
                        end
                        ACT_NEW:
                        begin
                            fill_next = '0;
                            pos_next  = '0;
                        end
                        default:
                        begin
                            fill_next = fill_reg;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            cnt_reg       <= '0;
            fill_reg      <= '0;
            pos_reg       <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_found_reg <= 1'b0;
            out_start_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            fill_reg      <= fill_next;
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
            out_found_reg <= out_found_next;
            out_start_reg <= out_start_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_found_reg;
    assign m_axis_tdata  = OUT_DATA_BITS'(out_start_reg);

    // a text word always leaves a result in the output register
    `ASSERT_CLK(a_text_gives_result, text_acc |=> m_axis_tvalid, "text word lost its result")
    // a match needs at least pattern_length characters since the text started
    `ASSERT_CLK(a_hit_needs_fill, (text_acc && hit) |-> (fill_next >= FILL_BITS'(len_reg)),
        "match reported on a short text")
    // the replay ends after one full rotation of the window
    `ASSERT_CLK(a_replay_ends,
        (state_reg == S_REPLAY && cnt_reg == SEL_BITS'(PATTERN_MAX - 1)) |=> (state_reg == S_RUN),
        "replay did not end")
    // fill count saturates at the window depth
    `ASSERT_ALWAYS(a_fill_bound, fill_reg <= FILL_BITS'(PATTERN_MAX), "window fill overflow")

endmodule
`default_nettype wire

[hw/rtl/wcsm_cell.sv]
`default_nettype none
module wcsm_cell
    import wcsm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cell_ctrl_t           ctrl,
    input  wire logic                 load_sel,
    input  wire logic [CHAR_BITS-1:0] win_in,
    input  wire logic                 link_in,
    output logic      [CHAR_BITS-1:0] win_out,
    output logic                      link_out,
    output logic                      link_next
);

    logic [CHAR_BITS-1:0] pattern_reg;
    logic [CHAR_BITS-1:0] window_reg;
    logic                 prefix_reg;
    logic                 prefix_next;

    // prefix ending here extends the one ending at the neighbor
    assign prefix_next = ctrl.valid & link_in & (ctrl.chr == pattern_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.load && load_sel)
        begin
            pattern_reg <= ctrl.chr;
        end
        if (ctrl.step)
        begin
            window_reg <= win_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            prefix_reg <= 1'b0;
        end
        else if (ctrl.step)
        begin
            prefix_reg <= prefix_next;
        end
    end

    assign win_out   = window_reg;
    assign link_out  = prefix_reg;
    assign link_next = prefix_next;

endmodule
`default_nettype wire

[hw/rtl/wcsm_chain.sv]
`default_nettype none
module wcsm_chain
    import wcsm_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cell_ctrl_t             ctrl,
    output logic [PATTERN_MAX-1:0]      match_next,
    output logic [CHAR_BITS-1:0]        win_last
);

    logic [CHAR_BITS-1:0]   win [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] link;

    for (genvar j = 0; j < PATTERN_MAX; j++)
    begin : g_cell
        logic [CHAR_BITS-1:0] win_in;
        logic                 link_in;
        logic                 load_sel;

        // cell 0 takes the head character and an empty prefix
        if (j == 0)
        begin : g_head
            assign win_in  = ctrl.chr;
            assign link_in = 1'b1;
        end
        else
        begin : g_body
            assign win_in  = win[j-1];
            assign link_in = link[j-1];
        end

        assign load_sel = (int'(ctrl.load_idx) == j);

        wcsm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .load_sel  (load_sel),
            .win_in    (win_in),
            .link_in   (link_in),
            .win_out   (win[j]),
            .link_out  (link[j]),
            .link_next (match_next[j])
        );
    end

    assign win_last = win[PATTERN_MAX-1];

endmodule
`default_nettype wire
